FILE: hdl/mefr_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mefr_pkg: shared types, constants and functions
// Frame geometry, register layout and group decode helpers for the
// Manchester edge frame receiver.
// -----------------------------------------------------------------------------
package mefr_pkg;

	localparam int FRAME_SLOTS = 44;
	localparam int GROUP_BITS  = 11;
	localparam int TIME_WIDTH  = 16;

	localparam int CFG_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	localparam int LAST_SLOT = FRAME_SLOTS - 1;
	localparam int SLOT_W    = $clog2(FRAME_SLOTS);
	localparam int BITS_KEPT = 2 * GROUP_BITS;
	localparam int BIT_IDX_W = $clog2(BITS_KEPT);
	localparam int BIT_CNT_W = $clog2(BITS_KEPT + 1);
	localparam int CMP_W     = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	localparam logic [CFG_W-1:0] SHORT_MIN_RST = CFG_W'(19);
	localparam logic [CFG_W-1:0] SHORT_MAX_RST = CFG_W'(28);
	localparam logic [CFG_W-1:0] LONG_MIN_RST  = CFG_W'(44);
	localparam logic [CFG_W-1:0] LONG_MAX_RST  = CFG_W'(56);

	typedef enum logic [1:0] {
		REG_SHORT_MIN = 2'd0,
		REG_SHORT_MAX = 2'd1,
		REG_LONG_MIN  = 2'd2,
		REG_LONG_MAX  = 2'd3
	} cfg_reg_t;

	typedef logic [BITS_KEPT-1:0] frame_bits_t;

	// Payload of one group, first received payload bit ends up as the MSB.
	function automatic logic [BYTE_W-1:0] group_payload(input frame_bits_t b, input int base);
		logic [BYTE_W-1:0] v;
		v = '0;
		for (int k = 2; k + 1 < GROUP_BITS; k++) begin
			v = {v[BYTE_W-2:0], b[base + k]};
		end
		return v;
	endfunction

	// Two start bits of one and a stop bit of zero.
	function automatic logic group_ok(input frame_bits_t b, input int base);
		return b[base] & b[base + 1] & ~b[base + GROUP_BITS - 1];
	endfunction

endpackage

FILE: hdl/mefr_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mefr_if: handshake channels of the frame receiver
// Edge channel (action plus timestamp) and result channel (two bytes and
// the framing flag), each with valid/ready.
// -----------------------------------------------------------------------------
interface mefr_edge_if import mefr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [TIME_WIDTH-1:0] edge_time;

	modport source (output valid, output action, output edge_time, input ready);
	modport sink   (input valid, input action, input edge_time, output ready);
endinterface

interface mefr_result_if import mefr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              frame_ok;
	logic [BYTE_W-1:0] low_byte;
	logic [BYTE_W-1:0] high_byte;

	modport source (output valid, output frame_ok, output low_byte, output high_byte,
		input ready);
	modport sink   (input valid, input frame_ok, input low_byte, input high_byte,
		output ready);
endinterface

FILE: hdl/manchester_edge_frame_receiver.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// manchester_edge_frame_receiver: Manchester frame decoder on edge timestamps
// Turns captured line-edge times into half-bit slots, decodes slot pairs into
// bits and reports the two payload bytes of a frame with a framing flag.
// -----------------------------------------------------------------------------
// Usage:
// The edge_in channel carries one transaction per captured line edge
// (action 0, edge_time = timer value) and one per end of frame (action 1).
// Edge transactions produce nothing on frame_out; each end-of-frame
// transaction produces exactly one frame_out transaction with frame_ok,
// low_byte and high_byte, and then the frame state starts over.
// A transaction is taken into an input register and, for an end of frame,
// placed in the output register that drives frame_out once it is free. One
// transaction is accepted per cycle unless an end of frame waits on a stalled
// output. Slot pairs are turned into bits as the slots fill, so the end of
// frame needs no separate decoding step. The gap windows are written over the
// APB port; the user must write them only while the block is idle, which the
// block does not enforce. pready is always high and reads return them. Reset
// clears the frame state and loads the default windows (19..28 for one slot,
// 44..56 for two). If frame_out is stalled with a result waiting, edges keep
// flowing; a second end of frame waits in the input register.
// -----------------------------------------------------------------------------
module manchester_edge_frame_receiver import mefr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mefr_edge_if.sink         edge_in,
	mefr_result_if.source     frame_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Configuration registers.
	logic [CFG_W-1:0] short_min_q, short_max_q, long_min_q, long_max_q;
	cfg_reg_t         reg_sel;

	// Input register.
	logic                  valid_s1;
	logic                  action_s1;
	logic [TIME_WIDTH-1:0] time_s1;

	// Frame state.
	logic [TIME_WIDTH-1:0] prev_time_q;
	logic                  seen_q;
	logic                  level_q;
	logic                  pend_q;      // value of the open pair's even slot
	logic [SLOT_W-1:0]     slot_cnt_q;  // next slot to be written
	frame_bits_t           bits_q;
	logic [BIT_CNT_W-1:0]  nbits_q;

	// Output register.
	logic              out_valid_q;
	logic              out_ok_q;
	logic [BYTE_W-1:0] out_lo_q, out_hi_q;

	logic                  out_free, adv;
	logic [TIME_WIDTH-1:0] gap;
	logic [CMP_W-1:0]      gap_x;
	logic                  in_short, in_long;
	logic                  w1, w2, append;
	logic [SLOT_W:0]       cnt_x;

	assign reg_sel = cfg_reg_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_sel)
			REG_SHORT_MIN: prdata = APB_DW'(short_min_q);
			REG_SHORT_MAX: prdata = APB_DW'(short_max_q);
			REG_LONG_MIN:  prdata = APB_DW'(long_min_q);
			REG_LONG_MAX:  prdata = APB_DW'(long_max_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= SHORT_MIN_RST;
			short_max_q <= SHORT_MAX_RST;
			long_min_q  <= LONG_MIN_RST;
			long_max_q  <= LONG_MAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_SHORT_MIN: short_min_q <= pwdata[CFG_W-1:0];
				REG_SHORT_MAX: short_max_q <= pwdata[CFG_W-1:0];
				REG_LONG_MIN:  long_min_q  <= pwdata[CFG_W-1:0];
				REG_LONG_MAX:  long_max_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// An edge never needs the output register; an end of frame moves on only
	// when the output register is empty or being emptied.
	assign out_free      = !out_valid_q || frame_out.ready;
	assign adv           = valid_s1 && (!action_s1 || out_free);
	assign edge_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			valid_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.ready && edge_in.valid) begin
			action_s1 <= edge_in.action;
			time_s1   <= edge_in.edge_time;
		end
	end

	// Gap classification, short window first. Before the first edge of a
	// frame no gap is measured.
	assign gap      = time_s1 - prev_time_q;
	assign gap_x    = CMP_W'(gap);
	assign in_short = seen_q && gap_x >= CMP_W'(short_min_q) && gap_x <= CMP_W'(short_max_q);
	assign in_long  = seen_q && !in_short &&
		gap_x >= CMP_W'(long_min_q) && gap_x <= CMP_W'(long_max_q);

	// At most two slots per edge, and the last slot is never written. Writing
	// an odd slot closes a pair; a pair of unequal slots yields its second one
	// as a bit. Two slots of one edge starting at an even slot close a pair of
	// equal values, which yields nothing.
	assign cnt_x  = {1'b0, slot_cnt_q};
	assign w1     = (in_short || in_long) && cnt_x < (SLOT_W + 1)'(LAST_SLOT);
	assign w2     = in_long && (cnt_x + 1'b1) < (SLOT_W + 1)'(LAST_SLOT);
	assign append = w1 && slot_cnt_q[0] && (pend_q != level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			seen_q      <= 1'b0;
			level_q     <= 1'b0;
			pend_q      <= 1'b0;
			slot_cnt_q  <= SLOT_W'(1);
			bits_q      <= '0;
			nbits_q     <= '0;
		end else if (adv) begin
			if (action_s1) begin
				// A still open pair at the end of frame pairs with a zero slot
				// and can only add a zero bit, which the cleared vector holds.
				prev_time_q <= '0;
				seen_q      <= 1'b0;
				level_q     <= 1'b0;
				pend_q      <= 1'b0;
				slot_cnt_q  <= SLOT_W'(1);
				bits_q      <= '0;
				nbits_q     <= '0;
			end else begin
				prev_time_q <= time_s1;
				seen_q      <= 1'b1;
				level_q     <= ~level_q;
				if ((w1 && !slot_cnt_q[0]) || (w2 && slot_cnt_q[0])) begin
					pend_q <= level_q;
				end
				slot_cnt_q <= slot_cnt_q + SLOT_W'(w1) + SLOT_W'(w2);
				if (append && nbits_q < BIT_CNT_W'(BITS_KEPT)) begin
					bits_q[nbits_q[BIT_IDX_W-1:0]] <= level_q;
					nbits_q                        <= nbits_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && action_s1) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && action_s1) begin
			out_ok_q <= group_ok(bits_q, 0) & group_ok(bits_q, GROUP_BITS);
			out_lo_q <= group_payload(bits_q, 0);
			out_hi_q <= group_payload(bits_q, GROUP_BITS);
		end
	end

	assign frame_out.valid     = out_valid_q;
	assign frame_out.frame_ok  = out_ok_q;
	assign frame_out.low_byte  = out_lo_q;
	assign frame_out.high_byte = out_hi_q;

	// The bit counter saturates at the number of bits the two groups use.
	a_nbits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nbits_q <= BIT_CNT_W'(BITS_KEPT))
		else $error("decoded bit count beyond the two groups");

	// The last slot of the frame is never written.
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_cnt_q} <= (SLOT_W + 1)'(LAST_SLOT))
		else $error("slot counter past the last writable slot");

	// An end of frame leaves a fully cleared frame behind.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && action_s1 |=> slot_cnt_q == SLOT_W'(1) && nbits_q == '0 && !seen_q &&
			!level_q && bits_q == '0)
		else $error("frame state not cleared after end of frame");

	// A result appears only for an end of frame that moved on.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && action_s1))
		else $error("result produced without an end of frame");

	// An edge waiting in the input register never blocks the input.
	a_edge_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !action_s1 |-> edge_in.ready)
		else $error("edge transaction stalled the input");

endmodule
